[rtl/core/scba_pkg.sv]
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and constants for the size class block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

	localparam int HEAPS_DEF      = 4;
	localparam int MAX_CLASS_DEF  = 15;
	localparam int POOL_PAGES_DEF = 8;
	localparam int MIN_CLASS_DEF  = 3;

	localparam logic [1:0] ST_ALLOC   = 2'd0;
	localparam logic [1:0] ST_TOO_BIG = 2'd1;
	localparam logic [1:0] ST_OOM     = 2'd2;
	localparam logic [1:0] ST_FREED   = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FREE_RD,
		S_FREE_WR,
		S_AL_CHECK,
		S_REFILL,
		S_POP_RD,
		S_POP_WR,
		S_NEXT_HEAP,
		S_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture the request
		logic head_rd;    // read head of the current list
		logic link_wr;    // write next_link[slot] = head
		logic head_set;   // head = slot, valid
		logic link_rd;    // read next_link[head]
		logic head_pop;   // head = link read
		logic refill_init;
		logic refill_step;
		logic next_heap;
		logic set_ok;
		logic set_oom;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_free;
		logic free_ok;
		logic too_big;
		logic head_valid;
		logic pool_left;
		logic refill_last;
		logic last_heap;
	} sts_t;

endpackage

[rtl/core/scba_ctrl.sv]
// ----------------------------------------------------------------------------
// scba_ctrl
// Sequencer for allocate, free and page refill.
// ----------------------------------------------------------------------------
module scba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  scba_pkg::sts_t sts,
	output scba_pkg::cmd_t cmd
);
	import scba_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_FREE_RD;
				end
			end
			S_FREE_RD: begin
				if (sts.is_free) begin
					if (sts.free_ok) begin
						cmd.head_rd = 1'b1;
						state_d     = S_FREE_WR;
					end else state_d = S_RESP;
				end else if (sts.too_big) state_d = S_RESP;
				else begin
					cmd.head_rd = 1'b1;
					state_d     = S_AL_CHECK;
				end
			end
			S_FREE_WR: begin
				cmd.link_wr  = 1'b1;
				cmd.head_set = 1'b1;
				state_d      = S_RESP;
			end
			S_AL_CHECK: begin
				if (sts.head_valid) begin
					cmd.link_rd = 1'b1;
					state_d     = S_POP_RD;
				end else if (sts.pool_left) begin
					cmd.refill_init = 1'b1;
					state_d         = S_REFILL;
				end else state_d = S_NEXT_HEAP;
			end
			S_REFILL: begin
				cmd.refill_step = 1'b1;
				cmd.link_wr     = 1'b1;
				cmd.head_set    = 1'b1;
				if (sts.refill_last) state_d = S_AL_CHECK;
			end
			S_POP_RD: begin
				state_d = S_POP_WR;
			end
			S_POP_WR: begin
				cmd.head_pop = 1'b1;
				cmd.set_ok   = 1'b1;
				state_d      = S_RESP;
			end
			S_NEXT_HEAP: begin
				if (sts.last_heap) begin
					cmd.set_oom = 1'b1;
					state_d     = S_RESP;
				end else begin
					cmd.next_heap = 1'b1;
					state_d       = S_FREE_RD;
				end
			end
			S_RESP: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("accept while holding result");
	a_refill_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REFILL && sts.refill_last) |=> state_q == S_AL_CHECK)
		else $error("refill did not return to check");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP_RD |-> $past(sts.head_valid)) else $error("pop of empty list");
`endif
endmodule

[rtl/core/scba_dp.sv]
// ----------------------------------------------------------------------------
// scba_dp
// Request registers, list heads, link memory and page refill counter.
// ----------------------------------------------------------------------------
module scba_dp #(
	parameter int HEAPS      = scba_pkg::HEAPS_DEF,
	parameter int MAX_CLASS  = scba_pkg::MAX_CLASS_DEF,
	parameter int POOL_PAGES = scba_pkg::POOL_PAGES_DEF,
	parameter int MIN_CLASS  = scba_pkg::MIN_CLASS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_type,
	input  logic [15:0]    request_bytes,
	input  logic [1:0]     home_heap,
	input  logic [17:0]    free_addr,
	input  logic [3:0]     free_class,
	input  logic [1:0]     free_heap,
	input  logic           free_is_system,
	input  scba_pkg::cmd_t cmd,
	output scba_pkg::sts_t sts,
	output logic [1:0]     status,
	output logic [17:0]    block_addr,
	output logic [3:0]     size_class,
	output logic [1:0]     heap_id
);
	import scba_pkg::*;

	localparam int NCLASS   = 16;
	localparam int NLISTS   = HEAPS * NCLASS;
	localparam int SLOT_W   = $clog2(POOL_PAGES) + MAX_CLASS - MIN_CLASS;
	localparam int NSLOTS   = 1 << SLOT_W;
	localparam int HW       = (HEAPS > 1) ? $clog2(HEAPS) : 1;
	localparam int LW       = HW + 4;
	localparam int PW       = $clog2(POOL_PAGES + 1);
	localparam int PAGE_SH  = MAX_CLASS - MIN_CLASS;
	localparam int POOL_B   = POOL_PAGES << MAX_CLASS;

	logic [SLOT_W-1:0] head_mem [NLISTS];
	logic [NLISTS-1:0] head_v_q;
	logic [SLOT_W:0]   link_mem [NSLOTS];  // valid bit on top

	logic              is_free_q, sys_q;
	logic [16:0]       need_q;
	logic [HW-1:0]     heap_q;
	logic [HW-1:0]     cnt_q;
	logic [3:0]        cls_q;
	logic [17:0]       faddr_q;
	logic [4:0]        fheap_q;
	logic [PW-1:0]     pages_q;
	logic [SLOT_W-1:0] slot_q, head_rd_q, rf_last_q;
	logic              hv_rd_q;
	logic [SLOT_W:0]   link_rd_q;
	logic [SLOT_W-1:0] rf_step_q;
	logic [1:0]        status_q;
	logic [17:0]       addr_q;

	logic [LW-1:0] li;
	logic [16:0]   need_in;
	logic [3:0]    cls_calc;
	logic [HW-1:0] home_mod;

	assign li = {heap_q, cls_q};

	// class is settled at load so the first head read uses the right list
	assign need_in = 17'(request_bytes) + 17'd2;

	always_comb begin
		cls_calc = 4'(MIN_CLASS);
		for (int c = MAX_CLASS; c >= MIN_CLASS; c--)
			if ((17'd1 << c) >= need_in) cls_calc = 4'(c);
	end

	assign home_mod = HW'(32'(home_heap) % HEAPS);

	// registered request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_free_q <= req_type;
			sys_q     <= free_is_system;
			need_q    <= need_in;
			faddr_q   <= free_addr;
			fheap_q   <= 5'(free_heap);
			heap_q    <= req_type ? HW'(free_heap) : home_mod;
			cls_q     <= req_type ? free_class : cls_calc;
			cnt_q     <= '0;
			status_q  <= ST_FREED;
			addr_q    <= '0;
		end else begin
			if (is_free_q && cmd.head_rd)
				slot_q <= SLOT_W'((32'(faddr_q) >> cls_q) << (cls_q - 4'(MIN_CLASS)));
			if (cmd.next_heap) begin
				heap_q <= (32'(heap_q) == HEAPS - 1) ? '0 : heap_q + 1'b1;
				cnt_q  <= cnt_q + 1'b1;
			end
			if (cmd.refill_init) begin
				slot_q    <= SLOT_W'(32'(pages_q) << PAGE_SH);
				rf_step_q <= SLOT_W'(1) << (cls_q - 4'(MIN_CLASS));
				rf_last_q <= SLOT_W'((32'(pages_q) << PAGE_SH) + (1 << PAGE_SH))
					- (SLOT_W'(1) << (cls_q - 4'(MIN_CLASS)));
			end else if (cmd.refill_step) slot_q <= slot_q + rf_step_q;
			if (cmd.set_ok) begin
				status_q <= ST_ALLOC;
				addr_q   <= 18'(32'(head_rd_q) << MIN_CLASS);
			end
			if (cmd.set_oom) status_q <= ST_OOM;
			if (cmd.head_rd && !is_free_q && need_q > (17'd1 << MAX_CLASS))
				status_q <= ST_TOO_BIG;
			if (!cmd.head_rd && !is_free_q && need_q > (17'd1 << MAX_CLASS))
				status_q <= ST_TOO_BIG;
		end
	end

	// list heads: read in one state, used the next; refill pushes update in place
	always_ff @(posedge clk) begin
		if (cmd.head_rd || cmd.refill_step || cmd.head_pop) begin
			head_rd_q <= cmd.head_pop ? link_rd_q[SLOT_W-1:0] :
				cmd.refill_step ? slot_q : head_mem[li];
			hv_rd_q   <= cmd.head_pop ? link_rd_q[SLOT_W] :
				cmd.refill_step ? 1'b1 : head_v_q[li];
		end
		if (cmd.head_set) head_mem[li] <= slot_q;
		if (cmd.head_pop) head_mem[li] <= link_rd_q[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= '0;
			pages_q  <= '0;
		end else begin
			if (cmd.head_set) head_v_q[li] <= 1'b1;
			if (cmd.head_pop) head_v_q[li] <= link_rd_q[SLOT_W];
			if (cmd.refill_init) pages_q <= pages_q + 1'b1;
		end
	end

	// link memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.link_wr) link_mem[slot_q] <= {hv_rd_q, head_rd_q};
		if (cmd.link_rd) link_rd_q <= link_mem[head_rd_q];
	end

	assign sts.is_free     = is_free_q;
	assign sts.free_ok     = !sys_q && (32'(fheap_q) < HEAPS) &&
		(cls_q >= 4'(MIN_CLASS)) && (32'(cls_q) <= MAX_CLASS) && (32'(faddr_q) < POOL_B);
	assign sts.too_big     = need_q > (17'd1 << MAX_CLASS);
	assign sts.head_valid  = hv_rd_q;
	assign sts.pool_left   = 32'(pages_q) < POOL_PAGES;
	assign sts.refill_last = slot_q == rf_last_q;
	assign sts.last_heap   = 32'(cnt_q) == HEAPS - 1;

	assign status     = status_q;
	assign block_addr = (status_q == ST_ALLOC) ? addr_q : '0;
	assign size_class = (status_q == ST_ALLOC) ? cls_q : '0;
	assign heap_id    = (status_q == ST_ALLOC) ? 2'(heap_q) : '0;

`ifndef NO_ASSERTIONS
	a_pages_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pages_q) <= POOL_PAGES) else $error("page count overrun");
	a_refill_needs_page: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.refill_init |-> sts.pool_left) else $error("refill without page");
	a_pop_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link_rd |-> hv_rd_q) else $error("link read of empty list");
`endif
endmodule

[rtl/core/size_class_block_allocator.sv]
// ----------------------------------------------------------------------------
// size_class_block_allocator
// Segregated free-list block allocator with per-heap, per-class LIFO lists.
// ----------------------------------------------------------------------------
// Usage: present an allocate or free request on the s_axis channel; one
// result transaction per request leaves on m_axis. The block takes one
// request at a time. A free reads the head of its list, then writes the
// freed block's link and makes that block the new head. An allocate
// checks the list of its home heap; if the list is empty and a page is
// left, it pushes every block of a new page onto that list and checks
// again, and if no page is left it moves on to the next heap, reporting
// out of memory once every heap has been tried. Too-big requests go
// straight to the result. The sequencer in scba_ctrl steps through these
// states, and the link memory has one write port and one read port.
// Reset clears all list valid bits and the page count; the link memory needs
// no clearing since a link is written whenever its slot is pushed.
// When the receiver stalls, the result holds on m_axis and s_axis_tready
// stays low until the result transaction completes.
// ----------------------------------------------------------------------------
module size_class_block_allocator #(
	parameter int HEAPS      = scba_pkg::HEAPS_DEF,
	parameter int MAX_CLASS  = scba_pkg::MAX_CLASS_DEF,
	parameter int POOL_PAGES = scba_pkg::POOL_PAGES_DEF,
	parameter int MIN_CLASS  = scba_pkg::MIN_CLASS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: request_bytes[15:0], home_heap[17:16], free_addr[35:18],
	// free_class[39:36], free_heap[41:40], free_is_system[42], zero fill
	input  logic [47:0] s_axis_tdata,
	// tuser: req_type
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: status[1:0], block_addr[19:2], size_class[23:20], heap_id[25:24],
	// zero fill
	output logic [31:0] m_axis_tdata
);
	import scba_pkg::*;

	cmd_t        cmd;
	sts_t        sts;
	logic [1:0]  status;
	logic [17:0] block_addr;
	logic [3:0]  size_class;
	logic [1:0]  heap_id;

	scba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.sts(sts), .cmd(cmd)
	);

	scba_dp #(
		.HEAPS(HEAPS), .MAX_CLASS(MAX_CLASS),
		.POOL_PAGES(POOL_PAGES), .MIN_CLASS(MIN_CLASS)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.req_type(s_axis_tuser),
		.request_bytes(s_axis_tdata[15:0]),
		.home_heap(s_axis_tdata[17:16]),
		.free_addr(s_axis_tdata[35:18]),
		.free_class(s_axis_tdata[39:36]),
		.free_heap(s_axis_tdata[41:40]),
		.free_is_system(s_axis_tdata[42]),
		.cmd(cmd), .sts(sts),
		.status(status), .block_addr(block_addr),
		.size_class(size_class), .heap_id(heap_id)
	);

	// pack result fields, lowest first
	assign m_axis_tdata = {6'd0, heap_id, size_class, block_addr, status};
endmodule
